// File: rtl/cise_pkg.sv
package cise_pkg;

   // Opcodes of the covered subset
   localparam logic [7:0] OPC_NOP       = 8'h00;
   localparam logic [7:0] OPC_LD_B_N    = 8'h06;
   localparam logic [7:0] OPC_LD_C_N    = 8'h0E;
   localparam logic [7:0] OPC_LD_D_N    = 8'h16;
   localparam logic [7:0] OPC_LD_E_N    = 8'h1E;
   localparam logic [7:0] OPC_LD_H_N    = 8'h26;
   localparam logic [7:0] OPC_LD_L_N    = 8'h2E;
   localparam logic [7:0] OPC_LD_HL_NN  = 8'h21;
   localparam logic [7:0] OPC_LDD_A_HL  = 8'h3A;
   localparam logic [7:0] OPC_LDD_HL_A  = 8'h32;
   localparam logic [7:0] OPC_DEC_BC    = 8'h0B;
   localparam logic [7:0] OPC_DEC_DE    = 8'h1B;
   localparam logic [7:0] OPC_DEC_HL    = 8'h2B;
   localparam logic [7:0] OPC_DEC_SP    = 8'h3B;
   localparam logic [7:0] OPC_DEC_B     = 8'h05;
   localparam logic [7:0] OPC_DEC_C     = 8'h0D;
   localparam logic [7:0] OPC_DEC_D     = 8'h15;
   localparam logic [7:0] OPC_DEC_E     = 8'h1D;
   localparam logic [7:0] OPC_DEC_H     = 8'h25;
   localparam logic [7:0] OPC_DEC_L     = 8'h2D;
   localparam logic [7:0] OPC_DEC_A     = 8'h3D;
   localparam logic [7:0] OPC_DEC_MHL   = 8'h35;
   localparam logic [7:0] OPC_XOR_B     = 8'hA8;
   localparam logic [7:0] OPC_XOR_C     = 8'hA9;
   localparam logic [7:0] OPC_XOR_D     = 8'hAA;
   localparam logic [7:0] OPC_XOR_E     = 8'hAB;
   localparam logic [7:0] OPC_XOR_H     = 8'hAC;
   localparam logic [7:0] OPC_XOR_L     = 8'hAD;
   localparam logic [7:0] OPC_XOR_A     = 8'hAF;
   localparam logic [7:0] OPC_JP_NN     = 8'hC3;
   localparam logic [7:0] OPC_JR_NZ     = 8'h20;
   localparam logic [7:0] OPC_JR_Z      = 8'h28;
   localparam logic [7:0] OPC_JR_NC     = 8'h30;
   localparam logic [7:0] OPC_JR_C      = 8'h38;

   // 8-bit register codes as carried in the opcode
   localparam logic [2:0] R8_B = 3'd0;
   localparam logic [2:0] R8_C = 3'd1;
   localparam logic [2:0] R8_D = 3'd2;
   localparam logic [2:0] R8_E = 3'd3;
   localparam logic [2:0] R8_H = 3'd4;
   localparam logic [2:0] R8_L = 3'd5;
   localparam logic [2:0] R8_A = 3'd7;

   // 16-bit pair codes
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   // Flag bit positions
   localparam int FLAG_Z_BIT = 3;
   localparam int FLAG_N_BIT = 2;
   localparam int FLAG_H_BIT = 1;
   localparam int FLAG_C_BIT = 0;

   localparam logic [15:0] ENTRY_RESET = 16'h0100;

   // Register index of entry_address on the configuration port
   localparam logic REG_ENTRY_ADDRESS = 1'b0;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LD_R_N,
      OP_LD_HL_NN,
      OP_LDD_A_HL,
      OP_LDD_HL_A,
      OP_DEC_R16,
      OP_DEC_R8,
      OP_DEC_MEM,
      OP_XOR,
      OP_JP,
      OP_JR,
      OP_ILLEGAL
   } op_kind_type;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] operand_low;
      logic [7:0] operand_high;
      logic [7:0] byte_at_hl;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic        illegal_opcode;
      logic [7:0]  acc_out;
      logic [3:0]  flag_bits;
      logic [15:0] pair_hl_out;
   } rsp_payload_type;

   typedef struct packed {
      op_kind_type kind;
      logic [2:0]  reg_code;
      logic [1:0]  pair_code;
      logic        cond_carry;
      logic        cond_set;
      logic [7:0]  operand_low;
      logic [7:0]  operand_high;
      logic [7:0]  byte_at_hl;
   } decoded_type;

   typedef struct packed {
      logic        load;
      logic [15:0] value;
   } pc_load_type;

endpackage

// File: rtl/cise_front.sv
// Classify the opcode and pull out register, pair and condition fields.
module cise_front (
   input  cise_pkg::req_payload_type item,
   output cise_pkg::decoded_type     decoded
);

   always_comb begin
      decoded.reg_code     = item.command[5:3];
      decoded.pair_code    = item.command[5:4];
      decoded.cond_carry   = item.command[4];
      decoded.cond_set     = item.command[3];
      decoded.operand_low  = item.operand_low;
      decoded.operand_high = item.operand_high;
      decoded.byte_at_hl   = item.byte_at_hl;

      case (item.command)
         cise_pkg::OPC_NOP: begin
            decoded.kind = cise_pkg::OP_NOP;
         end
         cise_pkg::OPC_LD_B_N, cise_pkg::OPC_LD_C_N, cise_pkg::OPC_LD_D_N,
         cise_pkg::OPC_LD_E_N, cise_pkg::OPC_LD_H_N, cise_pkg::OPC_LD_L_N: begin
            decoded.kind = cise_pkg::OP_LD_R_N;
         end
         cise_pkg::OPC_LD_HL_NN: begin
            decoded.kind = cise_pkg::OP_LD_HL_NN;
         end
         cise_pkg::OPC_LDD_A_HL: begin
            decoded.kind = cise_pkg::OP_LDD_A_HL;
         end
         cise_pkg::OPC_LDD_HL_A: begin
            decoded.kind = cise_pkg::OP_LDD_HL_A;
         end
         cise_pkg::OPC_DEC_BC, cise_pkg::OPC_DEC_DE, cise_pkg::OPC_DEC_HL,
         cise_pkg::OPC_DEC_SP: begin
            decoded.kind = cise_pkg::OP_DEC_R16;
         end
         cise_pkg::OPC_DEC_B, cise_pkg::OPC_DEC_C, cise_pkg::OPC_DEC_D,
         cise_pkg::OPC_DEC_E, cise_pkg::OPC_DEC_H, cise_pkg::OPC_DEC_L,
         cise_pkg::OPC_DEC_A: begin
            decoded.kind = cise_pkg::OP_DEC_R8;
         end
         cise_pkg::OPC_DEC_MHL: begin
            decoded.kind = cise_pkg::OP_DEC_MEM;
         end
         cise_pkg::OPC_XOR_B, cise_pkg::OPC_XOR_C, cise_pkg::OPC_XOR_D,
         cise_pkg::OPC_XOR_E, cise_pkg::OPC_XOR_H, cise_pkg::OPC_XOR_L,
         cise_pkg::OPC_XOR_A: begin
            decoded.kind     = cise_pkg::OP_XOR;
            // XOR names its source in the low three bits
            decoded.reg_code = item.command[2:0];
         end
         cise_pkg::OPC_JP_NN: begin
            decoded.kind = cise_pkg::OP_JP;
         end
         cise_pkg::OPC_JR_NZ, cise_pkg::OPC_JR_Z, cise_pkg::OPC_JR_NC,
         cise_pkg::OPC_JR_C: begin
            decoded.kind = cise_pkg::OP_JR;
         end
         default: begin
            decoded.kind = cise_pkg::OP_ILLEGAL;
         end
      endcase
   end

endmodule

// File: rtl/cise_queue.sv
// Small first-in first-out buffer of decoded instructions.
module cise_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cise_pkg::decoded_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output cise_pkg::decoded_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   cise_pkg::decoded_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/cise_back.sv
// Execute one decoded instruction per cycle, while the response is not
// stalled, against the register file and register the result.
module cise_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cise_pkg::pc_load_type    pc_load,
   input  logic                     head_valid,
   input  cise_pkg::decoded_type    head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cise_pkg::rsp_payload_type rsp_payload
);

   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in;
   logic [3:0]  flags_ff, flags_in;
   logic [7:0]  b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in, h_ff, h_in, l_ff, l_in;
   logic [15:0] sp_ff, sp_in;
   logic        rsp_valid_ff;
   cise_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [7:0]  src_r8;
   logic [15:0] src_pair;
   logic [15:0] hl;
   logic [7:0]  dec_old;
   logic [7:0]  dec_res;
   logic        r8_we;
   logic [7:0]  r8_wd;
   logic        pair_we;
   logic [1:0]  pair_code;
   logic [15:0] pair_wd;
   logic        cond_flag;
   logic        take;
   logic [15:0] jr_base;

   // Take a new instruction whenever the output register is free or draining
   assign pop         = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign hl          = {h_ff, l_ff};

   always_comb begin
      case (head.reg_code)
         cise_pkg::R8_B: src_r8 = b_ff;
         cise_pkg::R8_C: src_r8 = c_ff;
         cise_pkg::R8_D: src_r8 = d_ff;
         cise_pkg::R8_E: src_r8 = e_ff;
         cise_pkg::R8_H: src_r8 = h_ff;
         cise_pkg::R8_L: src_r8 = l_ff;
         cise_pkg::R8_A: src_r8 = a_ff;
         default:        src_r8 = b_ff;
      endcase
      case (head.pair_code)
         cise_pkg::PAIR_BC: src_pair = {b_ff, c_ff};
         cise_pkg::PAIR_DE: src_pair = {d_ff, e_ff};
         cise_pkg::PAIR_HL: src_pair = hl;
         default:           src_pair = sp_ff;
      endcase
   end

   always_comb begin
      pc_in     = pc_ff;
      a_in      = a_ff;
      flags_in  = flags_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      h_in      = h_ff;
      l_in      = l_ff;
      sp_in     = sp_ff;
      r8_we     = 1'b0;
      r8_wd     = head.operand_low;
      pair_we   = 1'b0;
      pair_code = head.pair_code;
      pair_wd   = src_pair - 16'd1;
      dec_old   = src_r8;
      cond_flag = head.cond_carry ? flags_ff[cise_pkg::FLAG_C_BIT]
                                  : flags_ff[cise_pkg::FLAG_Z_BIT];
      take      = head.cond_set ? cond_flag : !cond_flag;
      jr_base   = pc_ff + 16'd2;

      rsp_in                = '0;

      case (head.kind)
         cise_pkg::OP_NOP: begin
            pc_in = pc_ff + 16'd1;
         end
         cise_pkg::OP_LD_R_N: begin
            r8_we = 1'b1;
            r8_wd = head.operand_low;
            pc_in = pc_ff + 16'd2;
         end
         cise_pkg::OP_LD_HL_NN: begin
            pair_we   = 1'b1;
            pair_code = cise_pkg::PAIR_HL;
            pair_wd   = {head.operand_high, head.operand_low};
            pc_in     = pc_ff + 16'd3;
         end
         cise_pkg::OP_LDD_A_HL: begin
            a_in      = head.byte_at_hl;
            pair_we   = 1'b1;
            pair_code = cise_pkg::PAIR_HL;
            pair_wd   = hl - 16'd1;
            pc_in     = pc_ff + 16'd1;
         end
         cise_pkg::OP_LDD_HL_A: begin
            rsp_in.write_enable  = 1'b1;
            rsp_in.write_address = hl;
            rsp_in.write_data    = a_ff;
            pair_we              = 1'b1;
            pair_code            = cise_pkg::PAIR_HL;
            pair_wd              = hl - 16'd1;
            pc_in                = pc_ff + 16'd1;
         end
         cise_pkg::OP_DEC_R16: begin
            pair_we = 1'b1;
            pc_in   = pc_ff + 16'd1;
         end
         cise_pkg::OP_DEC_R8: begin
            r8_we = 1'b1;
            r8_wd = src_r8 - 8'd1;
            pc_in = pc_ff + 16'd1;
         end
         cise_pkg::OP_DEC_MEM: begin
            dec_old              = head.byte_at_hl;
            rsp_in.write_enable  = 1'b1;
            rsp_in.write_address = hl;
            rsp_in.write_data    = head.byte_at_hl - 8'd1;
            pc_in                = pc_ff + 16'd1;
         end
         cise_pkg::OP_XOR: begin
            a_in     = a_ff ^ src_r8;
            flags_in = '0;
            flags_in[cise_pkg::FLAG_Z_BIT] = ((a_ff ^ src_r8) == 8'd0);
            pc_in    = pc_ff + 16'd1;
         end
         cise_pkg::OP_JP: begin
            pc_in = {head.operand_high, head.operand_low};
         end
         cise_pkg::OP_JR: begin
            pc_in = take ? jr_base + {{8{head.operand_low[7]}}, head.operand_low} : jr_base;
         end
         default: begin
            rsp_in.illegal_opcode = 1'b1;
         end
      endcase

      // Shared decrement flags for DEC r and DEC (HL): carry is kept
      dec_res = dec_old - 8'd1;
      if (head.kind == cise_pkg::OP_DEC_R8 || head.kind == cise_pkg::OP_DEC_MEM) begin
         flags_in[cise_pkg::FLAG_Z_BIT] = (dec_res == 8'd0);
         flags_in[cise_pkg::FLAG_N_BIT] = 1'b1;
         flags_in[cise_pkg::FLAG_H_BIT] = (dec_old[3:0] == 4'd0);
         flags_in[cise_pkg::FLAG_C_BIT] = flags_ff[cise_pkg::FLAG_C_BIT];
      end

      if (r8_we) begin
         case (head.reg_code)
            cise_pkg::R8_B: b_in = r8_wd;
            cise_pkg::R8_C: c_in = r8_wd;
            cise_pkg::R8_D: d_in = r8_wd;
            cise_pkg::R8_E: e_in = r8_wd;
            cise_pkg::R8_H: h_in = r8_wd;
            cise_pkg::R8_L: l_in = r8_wd;
            cise_pkg::R8_A: a_in = r8_wd;
            default:        b_in = b_ff;
         endcase
      end

      if (pair_we) begin
         case (pair_code)
            cise_pkg::PAIR_BC: {b_in, c_in} = pair_wd;
            cise_pkg::PAIR_DE: {d_in, e_in} = pair_wd;
            cise_pkg::PAIR_HL: {h_in, l_in} = pair_wd;
            default:           sp_in = pair_wd;
         endcase
      end

      rsp_in.next_pc     = pc_in;
      rsp_in.acc_out     = a_in;
      rsp_in.flag_bits   = flags_in;
      rsp_in.pair_hl_out = {h_in, l_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= cise_pkg::ENTRY_RESET;
         a_ff         <= '0;
         flags_ff     <= '0;
         b_ff         <= '0;
         c_ff         <= '0;
         d_ff         <= '0;
         e_ff         <= '0;
         h_ff         <= '0;
         l_ff         <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pc_load.load) begin
            pc_ff <= pc_load.value;
         end else if (pop) begin
            pc_ff <= pc_in;
         end
         if (pop) begin
            a_ff     <= a_in;
            flags_ff <= flags_in;
            b_ff     <= b_in;
            c_ff     <= c_in;
            d_ff     <= d_in;
            e_ff     <= e_in;
            h_ff     <= h_in;
            l_ff     <= l_in;
            sp_ff    <= sp_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result until the far side takes it
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/cpu_instruction_subset_execute.sv
// Executes a small subset of an 8-bit CPU's instructions, one instruction per
// request transfer and one response transfer for each: NOP, LD r,n, LD HL,nn,
// LDD A,(HL), LDD (HL),A, DEC r8, DEC (HL), DEC r16, XOR r, JP nn and the four
// conditional JR forms. The caller supplies the opcode, the two bytes after it
// and the memory byte at the current HL; the response reports the next PC, an
// optional memory write (at the old HL), the accumulator, the flags and the new
// HL, which tells the caller where to fetch the next byte_at_hl. Unknown opcodes
// set illegal_opcode and change nothing. Throughput is one instruction per
// clock cycle while the response is not stalled: the decoder feeds a
// QUEUE_DEPTH-entry queue, and the execute stage retires one queued
// instruction per cycle into the response register. Each request is written
// into the queue, and its response is registered when the back end pops it.
// A stalled response holds the execute stage; the queue then fills and
// req_stall rises once it holds QUEUE_DEPTH instructions. Because each
// instruction depends on the state left by the one before it, the caller must
// supply byte_at_hl for the HL that the previous response reported. Writing
// entry_address (byte address 0) also reloads the program counter, as a restart
// at that address; write it only when no instruction is in flight.
module cpu_instruction_subset_execute #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cise_pkg::req_payload_type req_payload,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cise_pkg::rsp_payload_type rsp_payload,
   // configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [15:0]           entry_ff;
   logic                  cfg_write;
   logic                  entry_hit;
   cise_pkg::pc_load_type pc_load;
   cise_pkg::decoded_type decoded;
   cise_pkg::decoded_type head;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  push;
   logic                  pop;

   // Configuration: one register, zero wait states
   assign pready    = 1'b1;
   assign entry_hit = (paddr[2] == cise_pkg::REG_ENTRY_ADDRESS);
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = entry_hit ? {16'd0, entry_ff} : 32'd0;

   assign pc_load.load  = cfg_write && entry_hit;
   assign pc_load.value = pwdata[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= cise_pkg::ENTRY_RESET;
      end else if (pc_load.load) begin
         entry_ff <= pc_load.value;
      end
   end

   // Front: accept a transfer whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   cise_front u_front (
      .item    (req_payload),
      .decoded (decoded)
   );

   cise_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (decoded),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   // Back: execute in order and register the response
   cise_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pc_load     (pc_load),
      .head_valid  (!queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
